[rtl/wrsaw_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wrsaw_pkg
// Shared types, codes and constants of the wake-up radio stop-and-wait link.
// ----------------------------------------------------------------------------
package wrsaw_pkg;

    localparam int TIME_BITS_DEF = 32;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    localparam int IN_DATA_BITS  = 96;
    localparam int OUT_DATA_BITS = 56;

    localparam logic [2:0] HDR_TYPE_MASK   = 3'h7;
    localparam logic [7:0] MIN_DELIVER_LEN = 8'd3;

    localparam logic [15:0] DATA_TIMEOUT_RST = 16'd100;
    localparam logic [15:0] WAKE_TIMEOUT_RST = 16'd500;
    localparam logic [2:0]  ACK_MASK_RST     = 3'd4;
    localparam logic [2:0]  DATA_MASK_RST    = 3'd2;
    localparam logic [2:0]  WAKE_MASK_RST    = 3'd1;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_TX_NOTIFY    = 3'd0,
        CFG_RX_NOTIFY    = 3'd1,
        CFG_DATA_TIMEOUT = 3'd2,
        CFG_WAKE_TIMEOUT = 3'd3,
        CFG_ACK_MASK     = 3'd4,
        CFG_DATA_MASK    = 3'd5,
        CFG_WAKE_MASK    = 3'd6
    } cfg_idx_t;

    typedef enum logic [2:0] {
        OP_TICK      = 3'd0,
        OP_FRAME     = 3'd1,
        OP_SEND_WAKE = 3'd2,
        OP_SEND_DATA = 3'd3,
        OP_SEND_ACK  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        MODE_IDLE      = 2'd0,
        MODE_WAIT_DATA = 2'd1,
        MODE_WAIT_WAKE = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_BUSY   = 2'd1,
        STATUS_FAILED = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_WAKE = 2'd1,
        CMD_DATA = 2'd2,
        CMD_ACK  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        OUTCOME_NONE         = 3'd0,
        OUTCOME_ACKED        = 3'd1,
        OUTCOME_NACKED       = 3'd2,
        OUTCOME_DATA_TIMEOUT = 3'd3,
        OUTCOME_WAKE_TIMEOUT = 3'd4
    } outcome_t;

    typedef struct packed {
        logic        tx_notify_enable;
        logic        rx_notify_enable;
        logic [15:0] data_ack_timeout_ms;
        logic [15:0] wake_ack_timeout_ms;
        logic [2:0]  ack_flag_mask;
        logic [2:0]  data_flag_mask;
        logic [2:0]  wake_flag_mask;
    } cfg_t;

    typedef struct packed {
        op_t         opcode;
        logic [31:0] now_ms;
        logic [15:0] peer_address;
        logic [7:0]  frame_flags;
        logic [7:0]  frame_length;
        logic [15:0] wake_duration_ms;
        logic [7:0]  data_length;
        logic        data_is_ack;
        logic        seq_override_valid;
        logic        seq_override;
        logic        tx_ready;
    } in_item_t;

    typedef struct packed {
        status_t     request_status;
        cmd_t        tx_command;
        logic [15:0] tx_address;
        logic        tx_seq;
        logic        tx_is_ack;
        logic [7:0]  tx_length;
        logic [15:0] tx_wake_ms;
        outcome_t    tx_outcome;
        logic        deliver_frame;
        mode_t       link_mode;
    } out_item_t;

endpackage
`default_nettype wire

[rtl/wakeup_radio_stop_and_wait_link.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wakeup_radio_stop_and_wait_link
// Alternating-bit stop-and-wait link controller for a wake-up radio.
//
// Each input beat on the s_ group is one event: a tick, a received frame
// header, or a request to send a wake, data or ack frame. Each event gives
// exactly one result beat on the m_ group carrying the request status, the
// frame to launch, any transmit outcome, the delivery flag and the new mode.
// Configuration is written through cfg_we, cfg_addr and cfg_data, only while
// the block is idle; the user must keep to this, the block does not enforce it.
// An accepted beat sits in the input register while it is processed; its
// result is loaded into the result register once that can take it, which
// raises m_tvalid. One beat is taken every cycle while the receiver keeps
// m_tready high; the link state is registered on each step, so each event
// sees the updates of the event before it.
// Reset clears both registers, sets the mode to idle, the send time and
// expected sequence bit to zero and loads the configuration defaults.
// When the receiver holds m_tready low the result register keeps its beat,
// the input register fills, and s_tready then falls until the result is
// taken.
// ----------------------------------------------------------------------------
module wakeup_radio_stop_and_wait_link #(
    parameter int TIME_BITS = wrsaw_pkg::TIME_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [wrsaw_pkg::CFG_IDX_BITS-1:0]   cfg_addr,
    input  wire logic [wrsaw_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  wire logic                                s_tvalid,
    output wire logic                                s_tready,
    // now_ms, peer_address, frame_flags, frame_length, wake_duration_ms,
    // data_length, data_is_ack, seq_override_valid, seq_override, tx_ready
    input  wire logic [wrsaw_pkg::IN_DATA_BITS-1:0]   s_tdata,
    // opcode
    input  wire logic [2:0]                           s_tuser,
    output wire logic                                m_tvalid,
    input  wire logic                                m_tready,
    // request_status, tx_command, tx_address, tx_seq, tx_is_ack, tx_length,
    // tx_wake_ms, tx_outcome, deliver_frame, link_mode
    output wire logic [wrsaw_pkg::OUT_DATA_BITS-1:0]  m_tdata
);
    import wrsaw_pkg::*;

    cfg_t      cfg;
    in_item_t  item;
    out_item_t result;
    logic      item_valid;
    logic      can_load;
    logic      step;

    assign step = item_valid && can_load;

    wrsaw_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .cfg      (cfg)
    );

    wrsaw_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .take       (step),
        .item_valid (item_valid),
        .item       (item)
    );

    wrsaw_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .cfg    (cfg),
        .item   (item),
        .result (result)
    );

    wrsaw_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (step),
        .result   (result),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
`default_nettype wire

[rtl/wrsaw_cfg_regs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wrsaw_cfg_regs
// Configuration register file, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module wrsaw_cfg_regs (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [wrsaw_pkg::CFG_IDX_BITS-1:0]  cfg_addr,
    input  wire logic [wrsaw_pkg::CFG_DATA_BITS-1:0] cfg_data,
    output wrsaw_pkg::cfg_t                          cfg
);
    import wrsaw_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_addr))
                CFG_TX_NOTIFY:    cfg_next.tx_notify_enable    = cfg_data[0];
                CFG_RX_NOTIFY:    cfg_next.rx_notify_enable    = cfg_data[0];
                CFG_DATA_TIMEOUT: cfg_next.data_ack_timeout_ms = cfg_data[15:0];
                CFG_WAKE_TIMEOUT: cfg_next.wake_ack_timeout_ms = cfg_data[15:0];
                CFG_ACK_MASK:     cfg_next.ack_flag_mask       = cfg_data[2:0];
                CFG_DATA_MASK:    cfg_next.data_flag_mask      = cfg_data[2:0];
                CFG_WAKE_MASK:    cfg_next.wake_flag_mask      = cfg_data[2:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tx_notify_enable    <= 1'b0;
            cfg_reg.rx_notify_enable    <= 1'b0;
            cfg_reg.data_ack_timeout_ms <= DATA_TIMEOUT_RST;
            cfg_reg.wake_ack_timeout_ms <= WAKE_TIMEOUT_RST;
            cfg_reg.ack_flag_mask       <= ACK_MASK_RST;
            cfg_reg.data_flag_mask      <= DATA_MASK_RST;
            cfg_reg.wake_flag_mask      <= WAKE_MASK_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

[rtl/wrsaw_in_stage.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wrsaw_in_stage
// Input register: unpacks an accepted beat and holds it until the core
// takes it.
// ----------------------------------------------------------------------------
module wrsaw_in_stage (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output wire logic                               s_tready,
    input  wire logic [wrsaw_pkg::IN_DATA_BITS-1:0]  s_tdata,
    input  wire logic [2:0]                          s_tuser,
    input  wire logic                               take,
    output wire logic                               item_valid,
    output wrsaw_pkg::in_item_t                      item
);
    import wrsaw_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    in_item_t item_in;
    logic     load;

    assign s_tready = !valid_reg || take;
    assign load     = s_tvalid && s_tready;

    always_comb
    begin
        item_in.opcode             = op_t'(s_tuser);
        item_in.now_ms             = s_tdata[31:0];
        item_in.peer_address       = s_tdata[47:32];
        item_in.frame_flags        = s_tdata[55:48];
        item_in.frame_length       = s_tdata[63:56];
        item_in.wake_duration_ms   = s_tdata[79:64];
        item_in.data_length        = s_tdata[87:80];
        item_in.data_is_ack        = s_tdata[88];
        item_in.seq_override_valid = s_tdata[89];
        item_in.seq_override       = s_tdata[90];
        item_in.tx_ready           = s_tdata[91];
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_in;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule
`default_nettype wire

[rtl/wrsaw_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wrsaw_core
// Link state (mode, send time, expected sequence bit) and the single-pass
// step logic that turns one event into one result.
// ----------------------------------------------------------------------------
module wrsaw_core #(
    parameter int TIME_BITS = wrsaw_pkg::TIME_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step,
    input  wire wrsaw_pkg::cfg_t      cfg,
    input  wire wrsaw_pkg::in_item_t  item,
    output wrsaw_pkg::out_item_t      result
);
    import wrsaw_pkg::*;

    mode_t                mode_reg;
    mode_t                mode_next;
    logic [TIME_BITS-1:0] send_time_reg;
    logic [TIME_BITS-1:0] send_time_next;
    logic                 exp_seq_reg;
    logic                 exp_seq_next;

    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] elapsed;
    logic                 data_late;
    logic                 wake_late;
    logic [2:0]           hdr_type;
    logic                 frame_seq;
    logic                 has_ack;
    logic                 send_seq;
    out_item_t            res;

    assign now_t      = TIME_BITS'(item.now_ms);
    assign elapsed    = now_t - send_time_reg;
    assign data_late  = elapsed > TIME_BITS'(cfg.data_ack_timeout_ms);
    assign wake_late  = elapsed > TIME_BITS'(cfg.wake_ack_timeout_ms);
    assign hdr_type   = item.frame_flags[2:0] & HDR_TYPE_MASK;
    assign frame_seq  = item.frame_flags[0];
    assign has_ack    = |(hdr_type & cfg.ack_flag_mask);
    assign send_seq   = item.seq_override_valid ? item.seq_override : exp_seq_reg;

    always_comb
    begin
        res            = '0;
        mode_next      = mode_reg;
        send_time_next = send_time_reg;
        exp_seq_next   = exp_seq_reg;
        case (item.opcode)
            OP_TICK:
            begin
                if (mode_reg == MODE_WAIT_DATA && data_late && cfg.tx_notify_enable)
                begin
                    mode_next      = MODE_IDLE;
                    res.tx_outcome = OUTCOME_DATA_TIMEOUT;
                end
                else if (mode_reg == MODE_WAIT_WAKE && wake_late && cfg.tx_notify_enable)
                begin
                    mode_next      = MODE_IDLE;
                    res.tx_outcome = OUTCOME_WAKE_TIMEOUT;
                end
            end
            OP_FRAME:
            begin
                if (has_ack && cfg.tx_notify_enable)
                begin
                    mode_next      = MODE_IDLE;
                    res.tx_outcome = (exp_seq_reg == frame_seq) ? OUTCOME_ACKED
                                                                : OUTCOME_NACKED;
                    exp_seq_next   = !exp_seq_reg;
                end
                if (|(hdr_type & (cfg.data_flag_mask | cfg.wake_flag_mask)))
                begin
                    res.deliver_frame = (item.frame_length > MIN_DELIVER_LEN)
                                        && cfg.rx_notify_enable;
                    if (!has_ack && mode_next == MODE_IDLE && item.tx_ready)
                    begin
                        res.tx_command = CMD_ACK;
                        res.tx_address = item.peer_address;
                        res.tx_seq     = frame_seq;
                    end
                end
            end
            OP_SEND_WAKE, OP_SEND_DATA, OP_SEND_ACK:
            begin
                if (mode_reg != MODE_IDLE)
                begin
                    res.request_status = STATUS_BUSY;
                end
                else if (!item.tx_ready)
                begin
                    res.request_status = STATUS_FAILED;
                end
                else if (item.opcode == OP_SEND_WAKE)
                begin
                    res.tx_command = CMD_WAKE;
                    res.tx_address = item.peer_address;
                    res.tx_seq     = exp_seq_reg;
                    res.tx_wake_ms = item.wake_duration_ms;
                    send_time_next = now_t;
                    mode_next      = MODE_WAIT_WAKE;
                end
                else if (item.opcode == OP_SEND_DATA)
                begin
                    res.tx_command = CMD_DATA;
                    res.tx_address = item.peer_address;
                    res.tx_seq     = send_seq;
                    res.tx_is_ack  = item.data_is_ack;
                    res.tx_length  = item.data_length;
                    send_time_next = now_t;
                    mode_next      = MODE_WAIT_DATA;
                end
                else
                begin
                    res.tx_command = CMD_ACK;
                    res.tx_address = item.peer_address;
                    res.tx_seq     = send_seq;
                end
            end
            default:
            begin
                res = '0;
            end
        endcase
        res.link_mode = mode_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            send_time_reg <= '0;
            exp_seq_reg   <= 1'b0;
        end
        else if (step)
        begin
            mode_reg      <= mode_next;
            send_time_reg <= send_time_next;
            exp_seq_reg   <= exp_seq_next;
        end
    end

    assign result = res;

endmodule
`default_nettype wire

[rtl/wrsaw_out_stage.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wrsaw_out_stage
// Result register: holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module wrsaw_out_stage (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                load,
    input  wire wrsaw_pkg::out_item_t                 result,
    output wire logic                                can_load,
    output wire logic                                m_tvalid,
    input  wire logic                                m_tready,
    output wire logic [wrsaw_pkg::OUT_DATA_BITS-1:0]  m_tdata
);
    import wrsaw_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_item_t res_reg;

    assign can_load = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'b0000,
                       res_reg.link_mode,
                       res_reg.deliver_frame,
                       res_reg.tx_outcome,
                       res_reg.tx_wake_ms,
                       res_reg.tx_length,
                       res_reg.tx_is_ack,
                       res_reg.tx_seq,
                       res_reg.tx_address,
                       res_reg.tx_command,
                       res_reg.request_status};

endmodule
`default_nettype wire
